### rtl/core/crl_pkg.sv
// Shared types and constants for the clipped line rasteriser core.
package crl_pkg;

    localparam int COORD_BITS    = 16;
    localparam int DIM_BITS      = 13;
    localparam int CFG_ADDR_BITS = 1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_HOLD = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] x_start;
        logic signed [COORD_BITS-1:0] y_start;
        logic signed [COORD_BITS-1:0] x_end;
        logic signed [COORD_BITS-1:0] y_end;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         visible;
        logic                         last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic line_active;
    } dp_status_t;

endpackage

### rtl/core/crl_ctrl.sv
// Transfer controller: sequences loads and steps, owns the result valid.
module crl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_op,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  crl_pkg::dp_status_t status,
    output crl_pkg::dp_cmd_t    cmd
);

    crl_pkg::ctl_state_t state_reg;
    crl_pkg::ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crl_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crl_pkg::CTL_IDLE: begin
                if (cmd.step) begin
                    state_next = crl_pkg::CTL_HOLD;
                end
            end
            crl_pkg::CTL_HOLD: begin
                if (m_ready) begin
                    state_next = cmd.step ? crl_pkg::CTL_HOLD : crl_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = crl_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        m_valid  = 1'b0;
        case (state_reg)
            crl_pkg::CTL_IDLE: begin
                s_ready = 1'b1;
            end
            crl_pkg::CTL_HOLD: begin
                s_ready = m_ready;
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.load = s_valid && s_ready && (s_op == crl_pkg::OP_LOAD);
        cmd.step = s_valid && s_ready && (s_op == crl_pkg::OP_STEP) && status.line_active;
    end

endmodule

### rtl/core/crl_datapath.sv
// Line datapath: endpoint set-up, incremental quotient, clipping and result register.
module crl_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [crl_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [crl_pkg::DIM_BITS-1:0]         cfg_wdata,
    input  crl_pkg::in_item_t                    item,
    input  crl_pkg::dp_cmd_t                     cmd,
    output crl_pkg::dp_status_t                  status,
    output crl_pkg::out_item_t                   result
);

    localparam int CB = crl_pkg::COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = CB + 2;
    localparam int DB = crl_pkg::DIM_BITS;

    logic [DB-1:0]        width_reg;
    logic [DB-1:0]        height_reg;
    logic                 line_active_reg;
    logic [CB-1:0]        origin_x_reg;
    logic [CB-1:0]        origin_y_reg;
    logic                 y_major_reg;
    logic                 major_neg_reg;
    logic                 minor_neg_reg;
    logic [CB-1:0]        major_mag_reg;
    logic [CB-1:0]        minor_mag_reg;
    logic [CB-1:0]        step_mag_reg;
    logic [CB-1:0]        quot_reg;
    logic [CB-1:0]        rem_reg;
    crl_pkg::out_item_t   result_reg;

    // set-up
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        dx_mag;
    logic [DW-1:0]        dy_mag;
    logic                 ld_y_major;
    logic [CB-1:0]        ld_major_mag;

    // stepping
    logic [PW-1:0]        quot_ext;
    logic [PW-1:0]        step_ext;
    logic [PW-1:0]        minor_off;
    logic [PW-1:0]        major_off;
    logic [PW-1:0]        px;
    logic [PW-1:0]        py;
    logic                 vis;
    logic [CB-1:0]        step_inc;
    logic                 fin;
    logic [CB:0]          rem_sum;
    logic [CB:0]          rem_diff;
    logic                 rem_wrap;

    always_comb begin
        dx = $signed({item.x_end[CB-1], item.x_end}) -
             $signed({item.x_start[CB-1], item.x_start});
        dy = $signed({item.y_end[CB-1], item.y_end}) -
             $signed({item.y_start[CB-1], item.y_start});
        dx_mag = dx[DW-1] ? DW'(-dx) : DW'(dx);
        dy_mag = dy[DW-1] ? DW'(-dy) : DW'(dy);
        ld_y_major   = dy_mag > dx_mag;
        ld_major_mag = ld_y_major ? dy_mag[CB-1:0] : dx_mag[CB-1:0];
    end

    // minor offset = sign(minor) * floor(|i| * |minor| / |major|)
    always_comb begin
        quot_ext  = {2'b00, quot_reg};
        step_ext  = {2'b00, step_mag_reg};
        minor_off = minor_neg_reg ? PW'(-quot_ext) : quot_ext;
        major_off = major_neg_reg ? PW'(-step_ext) : step_ext;
        px = {{2{origin_x_reg[CB-1]}}, origin_x_reg} + (y_major_reg ? minor_off : major_off);
        py = {{2{origin_y_reg[CB-1]}}, origin_y_reg} + (y_major_reg ? major_off : minor_off);
        vis = !px[PW-1] && (px < {{(PW-DB){1'b0}}, width_reg}) &&
              !py[PW-1] && (py < {{(PW-DB){1'b0}}, height_reg});
        step_inc = step_mag_reg + CB'(1);
        fin      = step_inc == major_mag_reg;
        rem_sum  = {1'b0, rem_reg} + {1'b0, minor_mag_reg};
        rem_diff = rem_sum - {1'b0, major_mag_reg};
        rem_wrap = rem_sum >= {1'b0, major_mag_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                crl_pkg::CFG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                crl_pkg::CFG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
        end else if (cmd.load) begin
            line_active_reg <= ld_major_mag != '0;
        end else if (cmd.step && fin) begin
            line_active_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            origin_x_reg  <= item.x_start;
            origin_y_reg  <= item.y_start;
            y_major_reg   <= ld_y_major;
            major_neg_reg <= ld_y_major ? dy[DW-1] : dx[DW-1];
            minor_neg_reg <= ld_y_major ? dx[DW-1] : dy[DW-1];
            major_mag_reg <= ld_major_mag;
            minor_mag_reg <= ld_y_major ? dx_mag[CB-1:0] : dy_mag[CB-1:0];
            step_mag_reg  <= '0;
            quot_reg      <= '0;
            rem_reg       <= '0;
        end else if (cmd.step) begin
            step_mag_reg <= step_inc;
            quot_reg     <= rem_wrap ? quot_reg + CB'(1) : quot_reg;
            rem_reg      <= rem_wrap ? rem_diff[CB-1:0] : rem_sum[CB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            result_reg.pixel_x <= px[CB-1:0];
            result_reg.pixel_y <= py[CB-1:0];
            result_reg.visible <= vis;
            result_reg.last    <= fin;
        end
    end

    assign status.line_active = line_active_reg;
    assign result             = result_reg;

endmodule

### rtl/core/clipped_line_rasterizer_core.sv
// Top level of the clipped line rasteriser core.
//
//   channel   ports                            direction  carries
//   s_        s_valid s_ready s_payload        in         load or step item
//   m_        m_valid m_ready m_payload        out        one pixel per step on a live line
//   cfg_      cfg_wr_en cfg_addr cfg_wdata     in         screen width / height
//
// One item per cycle while no result is stalled: a step is resolved by the running
// quotient/remainder update (one add, compare and subtract) into the result register.
// A new item is taken while a held result is being drained in the same cycle.
// Reset (aresetn low at a clock edge) clears the screen size and drops any line.
// A stalled result holds s_ready low until m_ready is seen.
module clipped_line_rasterizer_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  crl_pkg::in_item_t                 s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output crl_pkg::out_item_t                m_payload,
    input  logic                              cfg_wr_en,
    input  logic [crl_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [crl_pkg::DIM_BITS-1:0]      cfg_wdata
);

    crl_pkg::dp_cmd_t    cmd;
    crl_pkg::dp_status_t status;

    crl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_payload.op),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    crl_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (s_payload),
        .cmd       (cmd),
        .status    (status),
        .result    (m_payload)
    );

endmodule

### bench/tb.sv
// Self-checking bench for the clipped line rasteriser: directed table, then random line traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crl_pkg::*;

    typedef struct {
        bit        is_cfg;
        cfg_reg_t  dim_sel;
        int        dim_val;
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } plan_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    in_item_t                 s_payload;
    logic                     m_valid;
    logic                     m_ready;
    out_item_t                m_payload;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [DIM_BITS-1:0]      cfg_wdata;

    // predictor state
    bit     line_live;
    bit     steep;
    longint idx;
    longint span_major;
    longint span_minor;
    longint org_x;
    longint org_y;
    longint scr_w;
    longint scr_h;

    out_item_t pixel_q[$];
    plan_row_t plan[$];
    int        mismatches;
    int        n_items;
    int        src_idle_pct;
    int        sink_stall_pct;

    clipped_line_rasterizer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Next pixel of the current line; returns 1 when the item yields a pixel.
    function automatic bit rasterize(input in_item_t it, output out_item_t pix);
        longint dx, dy, off, x, y;
        pix = '0;
        if (it.op == OP_LOAD) begin
            org_x      = longint'(it.x_start);
            org_y      = longint'(it.y_start);
            dx         = longint'(it.x_end) - org_x;
            dy         = longint'(it.y_end) - org_y;
            steep      = mag(dy) > mag(dx);
            span_major = steep ? dy : dx;
            span_minor = steep ? dx : dy;
            idx        = 0;
            line_live  = (span_major != 0);
            return 1'b0;
        end
        if (!line_live)
            return 1'b0;
        off = (idx * span_minor) / span_major;
        x   = steep ? org_x + off : org_x + idx;
        y   = steep ? org_y + idx : org_y + off;
        pix.pixel_x = x[COORD_BITS-1:0];
        pix.pixel_y = y[COORD_BITS-1:0];
        pix.visible = (x >= 0) && (x < scr_w) && (y >= 0) && (y < scr_h);
        idx = idx + ((span_major < 0) ? -1 : 1);
        pix.last = (idx == span_major);
        if (pix.last) begin
            line_live = 1'b0;
            idx       = 0;
        end
        return 1'b1;
    endfunction

    function automatic in_item_t random_fields();
        in_item_t it;
        it.op      = 1'($urandom);
        it.x_start = COORD_BITS'($urandom);
        it.y_start = COORD_BITS'($urandom);
        it.x_end   = COORD_BITS'($urandom);
        it.y_end   = COORD_BITS'($urandom);
        return it;
    endfunction

    function automatic plan_row_t blank_row();
        plan_row_t r;
        r.is_cfg  = 1'b0;
        r.dim_sel = CFG_SCREEN_WIDTH;
        r.dim_val = 0;
        r.item    = random_fields();
        r.item.op = OP_STEP;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic plan_row_t load_row(int xs, int ys, int xe, int ye);
        plan_row_t r;
        r = blank_row();
        r.item.op      = OP_LOAD;
        r.item.x_start = COORD_BITS'(xs);
        r.item.y_start = COORD_BITS'(ys);
        r.item.x_end   = COORD_BITS'(xe);
        r.item.y_end   = COORD_BITS'(ye);
        return r;
    endfunction

    function automatic plan_row_t pix_row(int px, int py, bit vis, bit fin);
        plan_row_t r;
        r = blank_row();
        r.typed        = 1'b1;
        r.want.pixel_x = COORD_BITS'(px);
        r.want.pixel_y = COORD_BITS'(py);
        r.want.visible = vis;
        r.want.last    = fin;
        return r;
    endfunction

    function automatic plan_row_t dim_row(cfg_reg_t sel, int val);
        plan_row_t r;
        r = blank_row();
        r.is_cfg  = 1'b1;
        r.dim_sel = sel;
        r.dim_val = val;
        return r;
    endfunction

    function automatic int near_edge(int lim);
        int r;
        r = $urandom_range(8);
        case ($urandom_range(2))
            0: return r - 4;
            1: return lim + r - 4;
            default: return $urandom_range(lim);
        endcase
    endfunction

    task automatic send_item(in_item_t it, bit typed, out_item_t want);
        out_item_t pix;
        int        gap;
        gap = 0;
        while (($urandom_range(99) < src_idle_pct) && (gap < 50))
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        n_items++;
        if (rasterize(it, pix)) begin
            if (typed)
                pixel_q.push_back(want);
            else
                pixel_q.push_back(pix);
        end
    endtask

    task automatic send_step();
        in_item_t it;
        it    = random_fields();
        it.op = OP_STEP;
        send_item(it, 1'b0, '0);
    endtask

    task automatic release_source();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic set_dim(cfg_reg_t sel, int val);
        release_source();
        while (pixel_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= sel;
        cfg_wdata <= DIM_BITS'(val);
        if (sel == CFG_SCREEN_WIDTH)
            scr_w = val;
        else
            scr_h = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic draw_line(int xs, int ys, int dx, int dy);
        plan_row_t r;
        int        steps;
        int        t;
        r     = load_row(xs, ys, xs + dx, ys + dy);
        steps = (mag(dx) >= mag(dy)) ? int'(mag(dx)) : int'(mag(dy));
        t     = $urandom_range(99);
        if (t < 10)
            steps = steps / 2;
        else if (t < 20)
            steps = steps + $urandom_range(1, 2);
        send_item(r.item, 1'b0, '0);
        repeat (steps) send_step();
    endtask

    task automatic random_traffic();
        in_item_t it;
        int       kind;
        int       m;
        int       sgn;
        kind = $urandom_range(99);
        sgn  = $urandom_range(1) ? 1 : -1;
        if (kind < 60) begin
            draw_line(near_edge(int'(scr_w)), near_edge(int'(scr_h)),
                      int'($urandom_range(24)) - 12, int'($urandom_range(24)) - 12);
        end else if (kind < 68) begin
            draw_line(near_edge(int'(scr_w)), near_edge(int'(scr_h)),
                      int'($urandom_range(200)) - 100, int'($urandom_range(200)) - 100);
        end else if (kind < 83) begin
            // full-range endpoints, only the head of the line is walked
            it    = random_fields();
            it.op = OP_LOAD;
            send_item(it, 1'b0, '0);
            repeat ($urandom_range(1, 6)) send_step();
        end else if (kind < 92) begin
            m = $urandom_range(16);
            case ($urandom_range(2))
                0: draw_line(near_edge(int'(scr_w)), near_edge(int'(scr_h)), sgn * m, 0);
                1: draw_line(near_edge(int'(scr_w)), near_edge(int'(scr_h)), 0, sgn * m);
                default: draw_line(near_edge(int'(scr_w)), near_edge(int'(scr_h)), sgn * m,
                                   ($urandom_range(1) ? m : -m));
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) send_item(random_fields(), 1'b0, '0);
        end
    endtask

    task automatic report_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge aclk) begin : check_pixels
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected pixel transfer, expected none, got x=%0d y=%0d",
                         $time, m_payload.pixel_x, m_payload.pixel_y);
                mismatches++;
            end else begin
                want = pixel_q.pop_front();
                report_field("pixel_x", want.pixel_x, m_payload.pixel_x);
                report_field("pixel_y", want.pixel_y, m_payload.pixel_y);
                report_field("visible", want.visible, m_payload.visible);
                report_field("last", want.last, m_payload.last);
            end
        end
    end

    initial begin : stimulus
        int target;
        int ph;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_payload      = '0;
        m_ready        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = CFG_SCREEN_WIDTH;
        cfg_wdata      = '0;
        mismatches     = 0;
        n_items        = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        line_live      = 1'b0;
        steep          = 1'b0;
        idx            = 0;
        span_major     = 0;
        span_minor     = 0;
        org_x          = 0;
        org_y          = 0;
        scr_w          = 0;
        scr_h          = 0;

        // screen is 0x0 out of reset, so every pixel is clipped
        plan.push_back(blank_row());
        plan.push_back(load_row(0, 0, 3, 1));
        plan.push_back(pix_row(0, 0, 0, 0));
        plan.push_back(pix_row(1, 0, 0, 0));
        plan.push_back(pix_row(2, 0, 0, 1));
        plan.push_back(blank_row());
        plan.push_back(dim_row(CFG_SCREEN_WIDTH, 4096));
        plan.push_back(dim_row(CFG_SCREEN_HEIGHT, 4096));
        plan.push_back(load_row(5, 5, 5, 5));
        plan.push_back(blank_row());
        plan.push_back(load_row(4095, 4095, 4097, 4094));
        plan.push_back(pix_row(4095, 4095, 1, 0));
        plan.push_back(pix_row(4096, 4095, 0, 1));
        plan.push_back(load_row(-32768, -32768, 32767, 32767));
        plan.push_back(pix_row(-32768, -32768, 0, 0));
        plan.push_back(pix_row(-32767, -32767, 0, 0));
        plan.push_back(load_row(32767, 0, -32768, 1));
        plan.push_back(pix_row(32767, 0, 0, 0));
        plan.push_back(pix_row(32766, 0, 0, 0));
        plan.push_back(load_row(0, 3, -2, 0));
        plan.push_back(pix_row(0, 3, 1, 0));
        plan.push_back(pix_row(0, 2, 1, 0));
        plan.push_back(pix_row(-1, 1, 0, 1));
        plan.push_back(load_row(10, 10, 20, 20));
        plan.push_back(load_row(7, 7, 7, 8));
        plan.push_back(pix_row(7, 7, 1, 1));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                set_dim(plan[i].dim_sel, plan[i].dim_val);
            else
                send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        target = n_items;
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin set_dim(CFG_SCREEN_WIDTH, 64);   set_dim(CFG_SCREEN_HEIGHT, 48);   end
                1: begin set_dim(CFG_SCREEN_WIDTH, 4096); set_dim(CFG_SCREEN_HEIGHT, 4096); end
                2: begin set_dim(CFG_SCREEN_WIDTH, 0);    set_dim(CFG_SCREEN_HEIGHT, 4096); end
                3: begin set_dim(CFG_SCREEN_WIDTH, 4096); set_dim(CFG_SCREEN_HEIGHT, 0);    end
                4: begin set_dim(CFG_SCREEN_WIDTH, 1);    set_dim(CFG_SCREEN_HEIGHT, 1);    end
                default: begin
                    set_dim(CFG_SCREEN_WIDTH, $urandom_range(4096));
                    set_dim(CFG_SCREEN_HEIGHT, $urandom_range(4096));
                end
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            target += 50;
            while (n_items < target)
                random_traffic();
        end

        release_source();
        while (pixel_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
rtl/core/crl_pkg.sv
rtl/core/crl_ctrl.sv
rtl/core/crl_datapath.sv
rtl/core/clipped_line_rasterizer_core.sv
bench/tb.sv
